[sv/hps_pkg.sv]
// hps_pkg: shared types and constants for the host power supervisor
// no dependencies; imported by every other file of the block

package hps_pkg;

  localparam int unsigned THRESH_W = 24;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned PHASE_W  = 3;

  localparam logic [MINUTE_W-1:0] MINUTES_PER_HOUR = MINUTE_W'(60);

  localparam logic [THRESH_W-1:0] STUCK_TICKS_RST   = THRESH_W'(120000);
  localparam logic [THRESH_W-1:0] ERROR_TICKS_RST   = THRESH_W'(300000);
  localparam logic [THRESH_W-1:0] START_TICKS_RST   = THRESH_W'(120000);
  localparam logic [MINUTE_W-1:0] SLEEP_MINUTES_RST = MINUTE_W'(2);

  typedef enum logic [PHASE_W-1:0] {
    PH_STARTING = 3'd0,
    PH_RUNNING  = 3'd1,
    PH_STOPPING = 3'd2,
    PH_STOPPED  = 3'd3,
    PH_SLEEPING = 3'd4,
    PH_ERROR    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    REG_STUCK_TICKS   = 2'd0,
    REG_ERROR_TICKS   = 2'd1,
    REG_START_TICKS   = 2'd2,
    REG_SLEEP_MINUTES = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [THRESH_W-1:0] stuck_ticks;
    logic [THRESH_W-1:0] error_ticks;
    logic [THRESH_W-1:0] start_ticks;
    logic [MINUTE_W-1:0] sleep_minutes;
  } cfg_t;

  typedef struct packed {
    phase_t              phase;
    logic                power;
    logic [MINUTE_W-1:0] wake_minute;
  } ctl_state_t;

endpackage

[sv/hps_if.sv]
// hps_if: valid/ready channel interfaces for tick items and status items
// depends on hps_pkg for field widths

interface hps_tick_if;
  import hps_pkg::*;
  logic                valid;
  logic                ready;
  logic                host_alive;
  logic                host_loaded;
  logic                wake_alarm;
  logic [MINUTE_W-1:0] rtc_minute;

  modport source(output valid, host_alive, host_loaded, wake_alarm, rtc_minute, input ready);
  modport sink(input valid, host_alive, host_loaded, wake_alarm, rtc_minute, output ready);
endinterface

interface hps_status_if;
  import hps_pkg::*;
  logic                valid;
  logic                ready;
  logic [PHASE_W-1:0]  phase;
  logic                power_on;
  logic                power_cycle;
  logic                alarm_arm;
  logic [MINUTE_W-1:0] alarm_minute;

  modport source(output valid, phase, power_on, power_cycle, alarm_arm, alarm_minute,
                 input ready);
  modport sink(input valid, phase, power_on, power_cycle, alarm_arm, alarm_minute,
               output ready);
endinterface

[sv/hps_step.sv]
// hps_step: next-state logic for one tick of the supervisor phase machine
// depends on hps_pkg

module hps_step #(
  parameter int unsigned TIMER_WIDTH = 24
) (
  input  hps_pkg::ctl_state_t             cur,
  input  logic [TIMER_WIDTH-1:0]          elapsed,
  input  hps_pkg::cfg_t                   cfg,
  input  logic                            host_alive,
  input  logic                            host_loaded,
  input  logic                            wake_alarm,
  input  logic [hps_pkg::MINUTE_W-1:0]    rtc_minute,
  output hps_pkg::ctl_state_t             nxt,
  output logic [TIMER_WIDTH-1:0]          elapsed_next,
  output logic                            power_cycle
);
  import hps_pkg::*;

  localparam int unsigned CMP_W = (TIMER_WIDTH > THRESH_W) ? TIMER_WIDTH : THRESH_W;

  logic [TIMER_WIDTH-1:0] e_inc;
  logic [TIMER_WIDTH-1:0] e_chk;
  logic [CMP_W-1:0]       e_inc_x;
  logic [CMP_W-1:0]       e_chk_x;
  logic [MINUTE_W:0]      min_sum;
  logic [MINUTE_W:0]      min_red1;
  logic [MINUTE_W-1:0]    min_mod;
  phase_t                 ph_chk;
  logic                   chk_changed;
  logic                   changed;

  // saturating tick count
  assign e_inc   = (elapsed == {TIMER_WIDTH{1'b1}}) ? elapsed : elapsed + 1'b1;
  assign e_inc_x = CMP_W'(e_inc);

  // wake minute modulo 60, sum stays below 2*60+7
  assign min_sum  = {1'b0, rtc_minute} + {1'b0, cfg.sleep_minutes};
  assign min_red1 = (min_sum >= {1'b0, MINUTES_PER_HOUR}) ?
                    min_sum - {1'b0, MINUTES_PER_HOUR} : min_sum;
  assign min_mod  = (min_red1 >= {1'b0, MINUTES_PER_HOUR}) ?
                    MINUTE_W'(min_red1 - {1'b0, MINUTES_PER_HOUR}) : MINUTE_W'(min_red1);

  // stuck and error timeouts
  always_comb begin
    ph_chk      = cur.phase;
    e_chk       = e_inc;
    chk_changed = 1'b0;
    if (cur.phase != PH_SLEEPING) begin
      if (cur.phase != PH_STOPPED && e_inc_x > CMP_W'(cfg.stuck_ticks) && !host_loaded) begin
        ph_chk      = PH_STOPPING;
        e_chk       = '0;
        chk_changed = 1'b1;
      end else if (e_inc_x > CMP_W'(cfg.error_ticks)) begin
        ph_chk      = PH_ERROR;
        e_chk       = '0;
        chk_changed = 1'b1;
      end
    end
  end

  assign e_chk_x = CMP_W'(e_chk);

  // phase handler
  always_comb begin
    nxt         = cur;
    nxt.phase   = ph_chk;
    changed     = chk_changed;
    power_cycle = 1'b0;
    unique case (ph_chk)
      PH_STARTING: begin
        if (host_alive) begin
          nxt.phase = PH_RUNNING;
          changed   = 1'b1;
        end else if (e_chk_x > CMP_W'(cfg.start_ticks)) begin
          nxt.phase = PH_ERROR;
          changed   = 1'b1;
        end
      end
      PH_RUNNING: begin
        if (!host_alive) begin
          nxt.phase = PH_STOPPING;
          changed   = 1'b1;
        end
      end
      PH_STOPPING: begin
        nxt.phase = PH_STOPPED;
        changed   = 1'b1;
      end
      PH_STOPPED: begin
        nxt.power       = 1'b0;
        nxt.wake_minute = min_mod;
        nxt.phase       = PH_SLEEPING;
        changed         = 1'b1;
      end
      PH_SLEEPING: begin
        if (wake_alarm) begin
          nxt.power = 1'b1;
          nxt.phase = PH_STARTING;
          changed   = 1'b1;
        end
      end
      PH_ERROR: begin
        power_cycle = !host_alive;
        nxt.power   = 1'b1;
        nxt.phase   = PH_STARTING;
        changed     = 1'b1;
      end
      default: begin
        nxt.power = 1'b1;
        nxt.phase = PH_STARTING;
        changed   = 1'b1;
      end
    endcase
  end

  assign elapsed_next = changed ? '0 : e_chk;

endmodule

[sv/host_power_supervisor_core.sv]
// host_power_supervisor_core: top level, config registers, phase state and status register
// depends on hps_pkg, hps_if and hps_step
//
//   channel  | dir | handshake    | payload
//   tick     | in  | valid/ready  | host_alive, host_loaded, wake_alarm, rtc_minute
//   status   | out | valid/ready  | phase, power_on, power_cycle, alarm_arm, alarm_minute
//   cfg      | in  | cfg_we       | cfg_index, cfg_data
//
// one tick per cycle while tick.ready is high; the status item shows in the cycle after the tick is taken
// the phase state updates in the same edge that loads the status register
// tick.ready is high while the status register is empty or being drained
// synchronous reset: starting phase, power on, counter and wake minute zero

module host_power_supervisor_core #(
  parameter int unsigned TIMER_WIDTH = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  hps_tick_if.sink                     tick,
  hps_status_if.source                 status,
  input  logic                         cfg_we,
  input  hps_pkg::cfg_reg_t            cfg_index,
  input  logic [hps_pkg::THRESH_W-1:0] cfg_data
);
  import hps_pkg::*;

  cfg_t                   cfg;
  ctl_state_t             state;
  ctl_state_t             state_next;
  logic [TIMER_WIDTH-1:0] elapsed;
  logic [TIMER_WIDTH-1:0] elapsed_next;
  logic                   cycle_next;
  logic                   accept;

  assign tick.ready = !status.valid || status.ready;
  assign accept     = tick.valid && tick.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stuck_ticks   <= STUCK_TICKS_RST;
      cfg.error_ticks   <= ERROR_TICKS_RST;
      cfg.start_ticks   <= START_TICKS_RST;
      cfg.sleep_minutes <= SLEEP_MINUTES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STUCK_TICKS:   cfg.stuck_ticks   <= cfg_data;
        REG_ERROR_TICKS:   cfg.error_ticks   <= cfg_data;
        REG_START_TICKS:   cfg.start_ticks   <= cfg_data;
        REG_SLEEP_MINUTES: cfg.sleep_minutes <= cfg_data[MINUTE_W-1:0];
        default: ;
      endcase
    end
  end

  hps_step #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_step (
    .cur          (state),
    .elapsed      (elapsed),
    .cfg          (cfg),
    .host_alive   (tick.host_alive),
    .host_loaded  (tick.host_loaded),
    .wake_alarm   (tick.wake_alarm),
    .rtc_minute   (tick.rtc_minute),
    .nxt          (state_next),
    .elapsed_next (elapsed_next),
    .power_cycle  (cycle_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase       <= PH_STARTING;
      state.power       <= 1'b1;
      state.wake_minute <= '0;
      elapsed           <= '0;
    end else if (accept) begin
      state   <= state_next;
      elapsed <= elapsed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status.valid <= 1'b0;
    end else if (accept) begin
      status.valid <= 1'b1;
    end else if (status.ready) begin
      status.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status.phase        <= state_next.phase;
      status.power_on     <= state_next.power;
      status.power_cycle  <= cycle_next;
      status.alarm_arm    <= (state_next.phase == PH_SLEEPING);
      status.alarm_minute <= state_next.wake_minute;
    end
  end

endmodule

[sv/hps_checker.sv]
// hps_checker: port-level assertions for host_power_supervisor_core, with its bind
// depends on hps_pkg and host_power_supervisor_core

module hps_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         tick_ready,
  input logic                         status_valid,
  input logic                         status_ready,
  input logic [hps_pkg::PHASE_W-1:0]  phase,
  input logic                         power_on,
  input logic                         power_cycle,
  input logic                         alarm_arm,
  input logic [hps_pkg::MINUTE_W-1:0] alarm_minute
);
  import hps_pkg::*;

  // power cycle only on the restart out of error
  a_cycle_restart: assert property (@(posedge clk) disable iff (rst)
    status_valid && power_cycle |-> power_on && phase == PH_STARTING)
    else $error("power cycle without restart");

  // armed alarm means sleeping with power off and a legal minute
  a_sleep_arm: assert property (@(posedge clk) disable iff (rst)
    status_valid && alarm_arm |->
      phase == PH_SLEEPING && !power_on && alarm_minute < MINUTES_PER_HOUR)
    else $error("bad sleep status");

  a_arm_phase: assert property (@(posedge clk) disable iff (rst)
    status_valid && phase == PH_SLEEPING |-> alarm_arm)
    else $error("sleeping without armed alarm");

  // an empty status register never blocks ticks
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !status_valid |-> tick_ready)
    else $error("tick stalled with empty status");

  a_status_hold: assert property (@(posedge clk) disable iff (rst)
    status_valid && !status_ready |=>
      status_valid && $stable(phase) && $stable(power_on) && $stable(power_cycle)
      && $stable(alarm_arm) && $stable(alarm_minute))
    else $error("stalled status item changed");

endmodule

bind host_power_supervisor_core hps_checker u_hps_checker (
  .clk          (clk),
  .rst          (rst),
  .tick_ready   (tick.ready),
  .status_valid (status.valid),
  .status_ready (status.ready),
  .phase        (status.phase),
  .power_on     (status.power_on),
  .power_cycle  (status.power_cycle),
  .alarm_arm    (status.alarm_arm),
  .alarm_minute (status.alarm_minute)
);
